>>> src/wavhp_pkg.sv
// ----------------------------------------------------------------------------
// wavhp_pkg: shared types and constants for the wav header parser
// chunk walk phases, riff tag codes and result status codes
// ----------------------------------------------------------------------------
`default_nettype none

package wavhp_pkg;

  // walk phase over the file
  typedef enum logic [1:0] {
    PH_PREAMBLE = 2'd0,
    PH_HEADER   = 2'd1,
    PH_BODY     = 2'd2,
    PH_PAD      = 2'd3
  } phase_e;

  // result status, first match wins in the order listed in the top level
  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_NO_RIFF  = 4'd2,
    ST_NO_WAVE  = 4'd3,
    ST_OVERRUN  = 4'd4,
    ST_FMT_BAD  = 4'd5,
    ST_DATA_BAD = 4'd6,
    ST_NOT_PCM  = 4'd7,
    ST_TOO_LONG = 4'd8
  } status_e;

  // four-character tags, first byte in the top byte
  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666D_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  localparam logic [32:0] MinFileLen  = 33'd44;
  localparam logic [31:0] MinFmtLen   = 32'd16;
  localparam logic [15:0] FormatPcm   = 16'd1;
  localparam logic [32:0] RiffTagPos  = 33'd3;
  localparam logic [32:0] WaveTagPos  = 33'd11;
  localparam int unsigned FmtBytes    = 16;

endpackage

`default_nettype wire

>>> src/wav_header_parser.sv
// ----------------------------------------------------------------------------
// wav_header_parser: streaming riff/wave header parser
// walks the chunk list of a wav file one byte per word and reports the pcm
// format fields plus data chunk offset and size at the final byte
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+----------------------------
//   in      | sink      | in_valid_i / in_ready_o | data_byte_i, last_byte_i
//   out     | source    | out_valid_o/out_ready_i | status_o + format fields
//
// one input word is taken per clock while in_ready_o is high; the walk state updates
// in the same cycle the word is accepted, and a final-byte word loads the result register
// the result appears the cycle after the final byte and holds until taken;
// input keeps flowing while the result register is free or being drained
// a result held by the receiver stalls every input word until it is taken
// reset (rst_ni low) clears the walk state and drops any pending result
// ----------------------------------------------------------------------------
`default_nettype none

module wav_header_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte stream in
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  // result out
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [3:0]  status_o,
  output      logic [15:0] channel_count_o,
  output      logic [31:0] sample_rate_o,
  output      logic [31:0] bytes_per_sec_o,
  output      logic [15:0] frame_bytes_o,
  output      logic [15:0] sample_bits_o,
  output      logic [31:0] data_offset_o,
  output      logic [31:0] data_length_o
);

  // --------------------------------------------------------------------------
  // walk state
  // --------------------------------------------------------------------------
  logic [32:0]          pos_q, pos_d;           // bytes seen, sticks at 2^32
  wavhp_pkg::phase_e    phase_q, phase_d;
  logic [2:0]           hdr_idx_q, hdr_idx_d;   // byte within 8-byte chunk header
  logic [31:0]          tag_q, tag_d;           // tag shifter / current chunk tag
  logic [31:0]          len_q, len_d;           // current chunk size
  logic [31:0]          remain_q, remain_d;     // body bytes still to come
  logic                 riff_ok_q, riff_ok_d;
  logic                 wave_ok_q, wave_ok_d;
  logic [15:0][7:0]     fmt_q, fmt_d;           // first 16 bytes of fmt body
  logic [31:0]          fmt_len_q, fmt_len_d;
  logic                 fmt_found_q, fmt_found_d;
  logic                 data_found_q, data_found_d;
  logic [31:0]          data_start_q, data_start_d;
  logic [31:0]          data_bytes_q, data_bytes_d;

  // state after this byte, before the end-of-file clear
  logic [32:0]          st_pos;
  wavhp_pkg::phase_e    st_phase;
  logic [2:0]           st_hdr_idx;
  logic [31:0]          st_tag;
  logic [31:0]          st_len;
  logic [31:0]          st_remain;
  logic                 st_riff_ok;
  logic                 st_wave_ok;
  logic [15:0][7:0]     st_fmt;
  logic [31:0]          st_fmt_len;
  logic                 st_fmt_found;
  logic                 st_data_found;
  logic [31:0]          st_data_start;
  logic [31:0]          st_data_bytes;

  logic [31:0]          hdr_tag_base;
  logic [31:0]          hdr_len_base;
  logic [31:0]          body_idx;               // offset of this byte in the body

  logic                 in_fire;
  logic                 file_end;
  wavhp_pkg::status_e   status;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [3:0]           status_q;
  logic [15:0]          channel_count_q;
  logic [31:0]          sample_rate_q;
  logic [31:0]          bytes_per_sec_q;
  logic [15:0]          frame_bytes_q;
  logic [15:0]          sample_bits_q;
  logic [31:0]          data_offset_q;
  logic [31:0]          data_length_q;

  // result slot is free or drains this cycle
  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;
  assign file_end   = in_fire & last_byte_i;

  assign hdr_tag_base = (hdr_idx_q == 3'd0) ? 32'd0 : tag_q;
  assign hdr_len_base = (hdr_idx_q == 3'd0) ? 32'd0 : len_q;
  assign body_idx     = len_q - remain_q;

  // --------------------------------------------------------------------------
  // one step of the chunk walk for the incoming byte
  // --------------------------------------------------------------------------
  always_comb begin
    st_pos        = pos_q;
    st_phase      = phase_q;
    st_hdr_idx    = hdr_idx_q;
    st_tag        = tag_q;
    st_len        = len_q;
    st_remain     = remain_q;
    st_riff_ok    = riff_ok_q;
    st_wave_ok    = wave_ok_q;
    st_fmt        = fmt_q;
    st_fmt_len    = fmt_len_q;
    st_fmt_found  = fmt_found_q;
    st_data_found = data_found_q;
    st_data_start = data_start_q;
    st_data_bytes = data_bytes_q;

    case (phase_q)
      wavhp_pkg::PH_PREAMBLE: begin
        // "RIFF" size "WAVE"
        st_tag = {tag_q[23:0], data_byte_i};
        if ((pos_q == wavhp_pkg::RiffTagPos) && (st_tag == wavhp_pkg::TagRiff)) begin
          st_riff_ok = 1'b1;
        end
        if (pos_q == wavhp_pkg::WaveTagPos) begin
          if (st_tag == wavhp_pkg::TagWave) begin
            st_wave_ok = 1'b1;
          end
          st_phase   = wavhp_pkg::PH_HEADER;
          st_hdr_idx = 3'd0;
        end
      end
      wavhp_pkg::PH_HEADER: begin
        // tag big-endian in bytes 0..3, size little-endian in bytes 4..7
        st_len = hdr_len_base;
        if (!hdr_idx_q[2]) begin
          st_tag = {hdr_tag_base[23:0], data_byte_i};
        end else begin
          st_tag = hdr_tag_base;
          st_len[{hdr_idx_q[1:0], 3'b000} +: 8] = data_byte_i;
        end
        if (hdr_idx_q == 3'd7) begin
          if (st_tag == wavhp_pkg::TagFmt) begin
            st_fmt_found = 1'b1;
            st_fmt_len   = st_len;
            st_fmt       = '0;
          end else if (st_tag == wavhp_pkg::TagData) begin
            st_data_found = 1'b1;
            st_data_start = pos_q[31:0] + 32'd1;
            st_data_bytes = st_len;
          end
          st_remain  = st_len;
          st_hdr_idx = 3'd0;
          st_phase   = (st_len != 32'd0) ? wavhp_pkg::PH_BODY : wavhp_pkg::PH_HEADER;
        end else begin
          st_hdr_idx = hdr_idx_q + 3'd1;
        end
      end
      wavhp_pkg::PH_BODY: begin
        if ((tag_q == wavhp_pkg::TagFmt) && (body_idx[31:4] == 28'd0)) begin
          st_fmt[body_idx[3:0]] = data_byte_i;
        end
        // remain is never zero while in the body
        st_remain = remain_q - 32'd1;
        if (remain_q == 32'd1) begin
          st_phase = len_q[0] ? wavhp_pkg::PH_PAD : wavhp_pkg::PH_HEADER;
        end
      end
      wavhp_pkg::PH_PAD: begin
        st_phase   = wavhp_pkg::PH_HEADER;
        st_hdr_idx = 3'd0;
      end
      default: begin
        st_phase = wavhp_pkg::PH_HEADER;
      end
    endcase

    if (!pos_q[32]) begin
      st_pos = pos_q + 33'd1;
    end
  end

  // --------------------------------------------------------------------------
  // end-of-file checks, first failing check wins
  // --------------------------------------------------------------------------
  always_comb begin
    if (st_pos[32]) begin
      status = wavhp_pkg::ST_TOO_LONG;
    end else if (st_pos < wavhp_pkg::MinFileLen) begin
      status = wavhp_pkg::ST_SHORT;
    end else if (!st_riff_ok) begin
      status = wavhp_pkg::ST_NO_RIFF;
    end else if (!st_wave_ok) begin
      status = wavhp_pkg::ST_NO_WAVE;
    end else if ((st_phase == wavhp_pkg::PH_BODY) && (st_remain != 32'd0)) begin
      status = wavhp_pkg::ST_OVERRUN;
    end else if (!st_fmt_found || (st_fmt_len < wavhp_pkg::MinFmtLen)) begin
      status = wavhp_pkg::ST_FMT_BAD;
    end else if (!st_data_found || (st_data_bytes == 32'd0)) begin
      status = wavhp_pkg::ST_DATA_BAD;
    end else if ({st_fmt[1], st_fmt[0]} != wavhp_pkg::FormatPcm) begin
      status = wavhp_pkg::ST_NOT_PCM;
    end else begin
      status = wavhp_pkg::ST_OK;
    end
  end

  // --------------------------------------------------------------------------
  // next state: hold when idle, step on a byte, clear after the final byte
  // --------------------------------------------------------------------------
  always_comb begin
    pos_d        = pos_q;
    phase_d      = phase_q;
    hdr_idx_d    = hdr_idx_q;
    tag_d        = tag_q;
    len_d        = len_q;
    remain_d     = remain_q;
    riff_ok_d    = riff_ok_q;
    wave_ok_d    = wave_ok_q;
    fmt_d        = fmt_q;
    fmt_len_d    = fmt_len_q;
    fmt_found_d  = fmt_found_q;
    data_found_d = data_found_q;
    data_start_d = data_start_q;
    data_bytes_d = data_bytes_q;
    if (file_end) begin
      // next byte starts a new file
      pos_d        = '0;
      phase_d      = wavhp_pkg::PH_PREAMBLE;
      hdr_idx_d    = '0;
      tag_d        = '0;
      len_d        = '0;
      remain_d     = '0;
      riff_ok_d    = 1'b0;
      wave_ok_d    = 1'b0;
      fmt_d        = '0;
      fmt_len_d    = '0;
      fmt_found_d  = 1'b0;
      data_found_d = 1'b0;
      data_start_d = '0;
      data_bytes_d = '0;
    end else if (in_fire) begin
      pos_d        = st_pos;
      phase_d      = st_phase;
      hdr_idx_d    = st_hdr_idx;
      tag_d        = st_tag;
      len_d        = st_len;
      remain_d     = st_remain;
      riff_ok_d    = st_riff_ok;
      wave_ok_d    = st_wave_ok;
      fmt_d        = st_fmt;
      fmt_len_d    = st_fmt_len;
      fmt_found_d  = st_fmt_found;
      data_found_d = st_data_found;
      data_start_d = st_data_start;
      data_bytes_d = st_data_bytes;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      phase_q      <= wavhp_pkg::PH_PREAMBLE;
      hdr_idx_q    <= '0;
      tag_q        <= '0;
      len_q        <= '0;
      remain_q     <= '0;
      riff_ok_q    <= 1'b0;
      wave_ok_q    <= 1'b0;
      fmt_q        <= '0;
      fmt_len_q    <= '0;
      fmt_found_q  <= 1'b0;
      data_found_q <= 1'b0;
      data_start_q <= '0;
      data_bytes_q <= '0;
    end else begin
      pos_q        <= pos_d;
      phase_q      <= phase_d;
      hdr_idx_q    <= hdr_idx_d;
      tag_q        <= tag_d;
      len_q        <= len_d;
      remain_q     <= remain_d;
      riff_ok_q    <= riff_ok_d;
      wave_ok_q    <= wave_ok_d;
      fmt_q        <= fmt_d;
      fmt_len_q    <= fmt_len_d;
      fmt_found_q  <= fmt_found_d;
      data_found_q <= data_found_d;
      data_start_q <= data_start_d;
      data_bytes_q <= data_bytes_d;
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (file_end) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // fields are zero on any failing status
  always_ff @(posedge clk_i) begin
    if (file_end) begin
      status_q <= status;
      if (status == wavhp_pkg::ST_OK) begin
        channel_count_q <= {st_fmt[3],  st_fmt[2]};
        sample_rate_q   <= {st_fmt[7],  st_fmt[6],  st_fmt[5],  st_fmt[4]};
        bytes_per_sec_q <= {st_fmt[11], st_fmt[10], st_fmt[9],  st_fmt[8]};
        frame_bytes_q   <= {st_fmt[13], st_fmt[12]};
        sample_bits_q   <= {st_fmt[15], st_fmt[14]};
        data_offset_q   <= st_data_start;
        data_length_q   <= st_data_bytes;
      end else begin
        channel_count_q <= '0;
        sample_rate_q   <= '0;
        bytes_per_sec_q <= '0;
        frame_bytes_q   <= '0;
        sample_bits_q   <= '0;
        data_offset_q   <= '0;
        data_length_q   <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign channel_count_o = channel_count_q;
  assign sample_rate_o   = sample_rate_q;
  assign bytes_per_sec_o = bytes_per_sec_q;
  assign frame_bytes_o   = frame_bytes_q;
  assign sample_bits_o   = sample_bits_q;
  assign data_offset_o   = data_offset_q;
  assign data_length_o   = data_length_q;

endmodule

`default_nettype wire
